@@ sv/vcpb_pkg.sv @@
// shared types and constants of the vertex color palette builder
`timescale 1ns / 1ps

package vcpb_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W         = PAL_AW + 1;
  localparam int unsigned MAX_VERTICES  = 65536;
  localparam int unsigned VTX_W         = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CHAN_W        = 16;
  localparam int unsigned KEY_W         = 4 * CHAN_W;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last_vertex;
  } in_word_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       is_new;
    logic       compress_ok;
    logic [8:0] color_total;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming word, restart the scan
    logic scan;    // walk the palette
    logic commit;  // update palette and counters, load the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/vertex_color_palette_builder.sv @@
// top level of the vertex color palette builder
`timescale 1ns / 1ps

// builds a palette of distinct rgba vertex colors, one word per vertex. each
// color is searched in the palette one entry per cycle through a single
// registered memory read port; a hit returns its index, a miss appends the
// color and returns the new index, and a miss on a full palette (256 entries)
// returns index 0 and marks the mesh as overflowed. a word is accepted, then
// the palette is read once per stored color and the final read is compared,
// and the result is committed once the output register is free; a hit ends
// the search early. on the word flagged last_vertex,
// compress_ok reports whether 4*colors <= 3*vertices with no overflow, and
// the counts then restart for the next mesh. the result sits in an output
// register, so a stalled result does not block accepting the next word.
// no clearing pass is needed after reset.

module vertex_color_palette_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vcpb_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vcpb_pkg::out_word_t out_word_o
);

  // command and status between controller and datapath
  vcpb_pkg::dp_cmd_t cmd;
  vcpb_pkg::dp_sts_t sts;

  // sequencing: accept, scan, commit
  vcpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // palette memory, counters and output register
  vcpb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ sv/vcpb_ctrl.sv @@
// controller state machine of the vertex color palette builder
`timescale 1ns / 1ps

module vcpb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vcpb_pkg::dp_sts_t sts_i,
  output vcpb_pkg::dp_cmd_t cmd_o
);

  vcpb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcpb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      vcpb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vcpb_pkg::ST_SCAN;
      end
      vcpb_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_d = vcpb_pkg::ST_FINISH;
      end
      vcpb_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = vcpb_pkg::ST_IDLE;
      end
      default: state_d = vcpb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    case (state_q)
      vcpb_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      vcpb_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      vcpb_pkg::ST_FINISH: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/vcpb_dp.sv @@
// datapath of the vertex color palette builder: palette memory, counters, output register
`timescale 1ns / 1ps

module vcpb_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vcpb_pkg::in_word_t in_word_i,
  input  vcpb_pkg::dp_cmd_t  cmd_i,
  output vcpb_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vcpb_pkg::out_word_t out_word_o
);

  localparam int unsigned AW  = vcpb_pkg::PAL_AW;
  localparam int unsigned CW  = vcpb_pkg::CNT_W;
  localparam int unsigned VW  = vcpb_pkg::VTX_W;
  localparam int unsigned KW  = vcpb_pkg::KEY_W;
  localparam int unsigned LW4 = CW + 2;  // width of 4*colors
  localparam int unsigned LW3 = VW + 2;  // width of 3*vertices
  localparam int unsigned CMP_W = (LW4 > LW3) ? LW4 : LW3;

  logic [KW-1:0] pal_mem [vcpb_pkg::PALETTE_DEPTH];

  // captured word
  logic [KW-1:0] key_q;
  logic          last_q;

  // counters
  logic [CW-1:0] color_count_q, color_count_d;
  logic [VW-1:0] vertex_count_q, vertex_count_d;
  logic          overflowed_q, overflowed_d;

  // scan
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic [AW-1:0] cmp_idx_q;
  logic          rd_vld_q, rd_vld_d;
  logic [KW-1:0] rd_data_q;
  logic          found_q;
  logic [AW-1:0] found_idx_q;

  // output register
  logic                out_valid_q, out_valid_d;
  vcpb_pkg::out_word_t out_word_q;

  logic hit, miss, rd_issue;
  logic full, do_write;
  logic [CW-1:0] count_new;
  logic [VW-1:0] vertex_new;
  logic [CMP_W-1:0] colors_x4, vertices_x3;
  vcpb_pkg::out_word_t res;

  assign hit      = rd_vld_q && (rd_data_q == key_q);
  assign miss     = (scan_idx_q == color_count_q) && !hit;
  assign rd_issue = cmd_i.scan && !hit && (scan_idx_q != color_count_q);

  assign sts_o.scan_done = hit || miss;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // commit arithmetic
  assign full     = (color_count_q == CW'(vcpb_pkg::PALETTE_DEPTH));
  assign do_write = cmd_i.commit && !found_q && !full;

  always_comb begin
    count_new  = color_count_q;
    vertex_new = vertex_count_q;
    if (!found_q && !full) count_new = color_count_q + CW'(1);
    if (vertex_count_q < VW'(vcpb_pkg::MAX_VERTICES)) begin
      vertex_new = vertex_count_q + VW'(1);
    end
  end

  assign colors_x4   = CMP_W'({count_new, 2'b00});
  assign vertices_x3 = CMP_W'({vertex_new, 1'b0}) + CMP_W'(vertex_new);

  always_comb begin
    res             = '0;
    res.is_new      = !found_q && !full;
    res.color_total = 9'(count_new);
    if (found_q) begin
      res.color_index = 8'(found_idx_q);
    end else if (!full) begin
      res.color_index = 8'(color_count_q[AW-1:0]);
    end
    res.compress_ok = last_q && !(colors_x4 > vertices_x3) &&
                      !(overflowed_q || (!found_q && full));
  end

  always_comb begin
    color_count_d  = color_count_q;
    vertex_count_d = vertex_count_q;
    overflowed_d   = overflowed_q;
    if (cmd_i.commit) begin
      if (last_q) begin
        color_count_d  = '0;
        vertex_count_d = '0;
        overflowed_d   = 1'b0;
      end else begin
        color_count_d  = count_new;
        vertex_count_d = vertex_new;
        overflowed_d   = overflowed_q || (!found_q && full);
      end
    end
  end

  always_comb begin
    scan_idx_d = scan_idx_q;
    rd_vld_d   = 1'b0;
    if (cmd_i.load) begin
      scan_idx_d = '0;
    end else if (rd_issue) begin
      scan_idx_d = scan_idx_q + CW'(1);
      rd_vld_d   = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q  <= '0;
      vertex_count_q <= '0;
      overflowed_q   <= 1'b0;
      scan_idx_q     <= '0;
      rd_vld_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      color_count_q  <= color_count_d;
      vertex_count_q <= vertex_count_d;
      overflowed_q   <= overflowed_d;
      scan_idx_q     <= scan_idx_d;
      rd_vld_q       <= rd_vld_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= {in_word_i.red, in_word_i.green, in_word_i.blue, in_word_i.alpha};
      last_q <= in_word_i.last_vertex;
    end
    if (rd_issue) begin
      cmp_idx_q <= scan_idx_q[AW-1:0];
    end
    if (cmd_i.scan && (hit || miss)) begin
      found_q     <= hit;
      found_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      out_word_q <= res;
    end
  end

  // palette memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      pal_mem[color_count_q[AW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_data_q <= pal_mem[scan_idx_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ verif/vertex_color_palette_builder_tb.sv @@
// self-checking testbench of the vertex color palette builder
`timescale 1ns / 1ps

module vertex_color_palette_builder_tb;

  localparam int unsigned CHAN_W = vcpb_pkg::CHAN_W;
  localparam int unsigned KEY_W = vcpb_pkg::KEY_W;
  localparam int unsigned PALETTE_DEPTH = vcpb_pkg::PALETTE_DEPTH;
  localparam int unsigned MAX_VERTICES = vcpb_pkg::MAX_VERTICES;
  localparam int unsigned CLK_HALF_NS = 10;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS = 930;
  localparam int unsigned HOLD_AT_WORD = 30;     // accepted words before the long hold-off
  localparam int unsigned LONG_HOLD = 1500;      // cycles the result side holds off
  localparam int unsigned DRAIN_CYCLES = 300;    // one full-palette search plus margin
  localparam longint unsigned TIMEOUT_NS = 64'd40_000_000;
  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;
  localparam logic [CHAN_W-1:0] CHAN_MSB = {1'b1, {(CHAN_W - 1){1'b0}}};

  // one pending input word with its lead-in gap
  typedef struct {
    vcpb_pkg::in_word_t word;
    int unsigned gap;
    bit drain;      // wait until every result is back before offering
  } vertex_stim_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  vcpb_pkg::in_word_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  vcpb_pkg::out_word_t out_word_o;

  vertex_stim_t vertex_q[$];
  vcpb_pkg::out_word_t index_expect_q[$];

  // shadow copy of the palette and the mesh counters
  logic [KEY_W-1:0] shadow_palette[PALETTE_DEPTH];
  int unsigned shadow_colors;
  int unsigned shadow_vertices;
  bit shadow_overflow;

  // sender and receiver bookkeeping
  vertex_stim_t cur_stim;
  bit offering;
  bit word_taken;
  int unsigned gap_cnt;
  int unsigned stall_left;
  int unsigned run_left;
  bit hold_done;

  // run statistics
  int unsigned words_in;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned appends;
  int unsigned hits;
  int unsigned full_misses;
  int unsigned meshes;
  int unsigned meshes_ok;
  int unsigned in_stalled_cycles;

  vertex_color_palette_builder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // search the shadow palette, append on a miss, decide on the last vertex
  function automatic vcpb_pkg::out_word_t palette_lookup(vcpb_pkg::in_word_t w);
    logic [KEY_W-1:0] key;
    vcpb_pkg::out_word_t r;
    bit hit;
    bit fresh;
    bit ok;
    int unsigned idx;
    key = {w.red, w.green, w.blue, w.alpha};
    hit = 1'b0;
    fresh = 1'b0;
    ok = 1'b0;
    idx = 0;
    // only entries already written are searched, first match wins
    for (int unsigned i = 0; i < shadow_colors; i++) begin
      if (!hit && shadow_palette[i] == key) begin
        hit = 1'b1;
        idx = i;
      end
    end
    if (hit) begin
      hits++;
    end else if (shadow_colors < PALETTE_DEPTH) begin
      shadow_palette[shadow_colors] = key;
      idx = shadow_colors;
      shadow_colors++;
      fresh = 1'b1;
      appends++;
    end else begin
      // full palette: color dropped, index 0, mesh marked overflowed
      shadow_overflow = 1'b1;
      idx = 0;
      full_misses++;
    end
    if (shadow_vertices < MAX_VERTICES) shadow_vertices++;
    r.color_index = 8'(idx);
    r.is_new = fresh;
    r.color_total = 9'(shadow_colors);
    if (w.last_vertex) begin
      // an entry costs four indexes: palette pays off when 4*colors <= 3*vertices
      ok = (4 * shadow_colors <= 3 * shadow_vertices) && !shadow_overflow;
      meshes++;
      if (ok) meshes_ok++;
      shadow_colors = 0;
      shadow_vertices = 0;
      shadow_overflow = 1'b0;
    end
    r.compress_ok = ok;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 80);
  endfunction

  function automatic logic [KEY_W-1:0] random_color();
    return {$urandom(), $urandom()};
  endfunction

  function automatic vcpb_pkg::in_word_t make_word(logic [KEY_W-1:0] key, bit is_last);
    vcpb_pkg::in_word_t w;
    {w.red, w.green, w.blue, w.alpha} = key;
    w.last_vertex = is_last;
    return w;
  endfunction

  task automatic add_vertex(logic [KEY_W-1:0] key, bit is_last, int unsigned gap, bit drain);
    vertex_stim_t s;
    s.word = make_word(key, is_last);
    s.gap = gap;
    s.drain = drain;
    vertex_q = {vertex_q, s};
  endtask

  // fill the palette with distinct colors, add extra_new more past it, then revisit
  // stored colors; the red channel carries the entry number so keys differ
  task automatic add_full_mesh(int unsigned extra_new, int unsigned revisits);
    logic [KEY_W-1:0] stored[$];
    logic [KEY_W-1:0] key;
    int unsigned total;
    int unsigned n;
    total = PALETTE_DEPTH + extra_new + revisits;
    for (n = 0; n < PALETTE_DEPTH + extra_new; n++) begin
      key = random_color();
      key[KEY_W-1 -: CHAN_W] = CHAN_W'(n);
      if (n < PALETTE_DEPTH) stored = {stored, key};
      add_vertex(key, n == total - 1, pick_gap(), 1'b0);
    end
    for (n = PALETTE_DEPTH + extra_new; n < total; n++)
      add_vertex(stored[$urandom_range(0, PALETTE_DEPTH - 1)], n == total - 1,
                 pick_gap(), 1'b0);
  endtask

  // short meshes drawn from a small color pool, with near misses and strays
  task automatic add_pool_mesh(int unsigned len, bit drain_first);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] key;
    int unsigned pool_size;
    int unsigned roll;
    int unsigned n;
    bit busy;
    pool_size = $urandom_range(1, len);
    busy = ($urandom_range(0, 3) == 0);
    for (n = 0; n < pool_size; n++) pool = {pool, random_color()};
    for (n = 0; n < len; n++) begin
      roll = $urandom_range(0, 9);
      key = pool[$urandom_range(0, pool_size - 1)];
      if (roll == 0) key = random_color();
      else if (roll == 1) key = key ^ (64'd1 << $urandom_range(0, KEY_W - 1));
      add_vertex(key, n == len - 1, busy ? 0 : pick_gap(), drain_first && n == 0);
    end
  endtask

  // result side: random stall stretches, stall-free runs, one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && words_in >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(0, 40);
          stall_left = pick_gap();
        end
      end
    end
  end

  // input side: one word at a time from the pending queue, after its gap
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (word_taken) begin
        word_taken = 1'b0;
        offering = 1'b0;
      end
      if (!offering && vertex_q.size() != 0) begin
        if (gap_cnt < vertex_q[0].gap) begin
          gap_cnt++;
        end else if (!vertex_q[0].drain || index_expect_q.size() == 0) begin
          cur_stim = vertex_q.pop_front();
          offering = 1'b1;
          gap_cnt = 0;
        end
      end
      // valid stays high across back-to-back words, one assignment per step
      in_valid_i <= offering;
      if (offering) in_word_i <= cur_stim.word;
    end
  end

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // handshakes seen at the rising edge: predict on accept, compare on delivery
  always @(posedge clk_i) begin
    vcpb_pkg::out_word_t want;
    vcpb_pkg::out_word_t pred;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pred = palette_lookup(in_word_i);
        index_expect_q = {index_expect_q, pred};
        words_in++;
        word_taken = 1'b1;
      end
      if (in_valid_i && in_stall_o) in_stalled_cycles++;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (index_expect_q.size() == 0) begin
          $display("%0t ns: unexpected result, got index %0d total %0d",
                   $time, out_word_o.color_index, out_word_o.color_total);
          errors++;
        end else begin
          want = index_expect_q.pop_front();
          check_field("color_index", want.color_index, out_word_o.color_index);
          check_field("is_new", want.is_new, out_word_o.is_new);
          check_field("compress_ok", want.compress_ok, out_word_o.compress_ok);
          check_field("color_total", want.color_total, out_word_o.color_total);
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [KEY_W-1:0] all_ones;
    logic [KEY_W-1:0] all_zero;
    logic [KEY_W-1:0] red_msb;
    logic [KEY_W-1:0] green_msb;
    logic [KEY_W-1:0] blue_msb;
    logic [KEY_W-1:0] alpha_msb;
    logic [KEY_W-1:0] alpha_lsb;
    int unsigned planned;
    int unsigned len;
    int unsigned roll;
    int unsigned mesh_no;
    int unsigned n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    offering = 1'b0;
    word_taken = 1'b0;
    gap_cnt = 0;
    stall_left = 0;
    run_left = 0;
    hold_done = 1'b0;
    shadow_colors = 0;
    shadow_vertices = 0;
    shadow_overflow = 1'b0;

    all_ones = {4{CHAN_MAX}};
    all_zero = '0;
    red_msb = {CHAN_MSB, {3 * CHAN_W{1'b0}}};
    green_msb = {{CHAN_W{1'b0}}, CHAN_MSB, {2 * CHAN_W{1'b0}}};
    blue_msb = {{2 * CHAN_W{1'b0}}, CHAN_MSB, {CHAN_W{1'b0}}};
    alpha_msb = {{3 * CHAN_W{1'b0}}, CHAN_MSB};
    alpha_lsb = 64'd1;

    // single black vertex: one color for one vertex never pays off
    add_vertex(all_zero, 1'b1, 0, 1'b0);
    // extremes alternating: two colors over four vertices pays off
    add_vertex(all_ones, 1'b0, 0, 1'b0);
    add_vertex(all_zero, 1'b0, 0, 1'b0);
    add_vertex(all_ones, 1'b0, 0, 1'b0);
    add_vertex(all_zero, 1'b1, 0, 1'b0);
    // three colors over four vertices sits right on the boundary
    add_vertex(all_ones, 1'b0, pick_gap(), 1'b1);
    add_vertex(all_zero, 1'b0, 0, 1'b0);
    add_vertex(red_msb, 1'b0, 0, 1'b0);
    add_vertex(all_ones, 1'b1, 0, 1'b0);
    // one bit apart in each channel: four distinct colors, just too many
    add_vertex(green_msb, 1'b0, pick_gap(), 1'b0);
    add_vertex(blue_msb, 1'b0, 0, 1'b0);
    add_vertex(alpha_msb, 1'b0, 0, 1'b0);
    add_vertex(alpha_lsb, 1'b1, 0, 1'b0);
    // alpha lsb against black must not match
    add_vertex(all_zero, 1'b0, 0, 1'b0);
    add_vertex(alpha_lsb, 1'b0, 0, 1'b0);
    add_vertex(all_zero, 1'b1, 0, 1'b0);
    // one repeated color
    for (n = 0; n < 5; n++) add_vertex(all_ones, n == 4, 0, 1'b0);
    planned = vertex_q.size();

    // random meshes; two of them fill the palette
    mesh_no = 0;
    while (planned < RANDOM_WORDS) begin
      if (mesh_no == 6) begin
        // full palette, no overflow, and exactly enough vertices to pay off
        add_full_mesh(0, (4 * PALETTE_DEPTH + 2) / 3 - PALETTE_DEPTH);
      end else if (mesh_no == 14) begin
        // spills past the palette: overflow forces a failed decision
        add_full_mesh(6, 10);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) len = $urandom_range(1, 12);
        else if (roll < 95) len = $urandom_range(13, 40);
        else len = $urandom_range(41, 90);
        add_pool_mesh(len, mesh_no == 0 || $urandom_range(0, 7) == 0);
      end
      planned = vertex_q.size();
      mesh_no++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (vertex_q.size() != 0 || offering || index_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (index_expect_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, index_expect_q.size());
      errors++;
    end
    $display("covered %0d vertices in %0d meshes: %0d appends, %0d hits, %0d full-palette misses",
             words_in, meshes, appends, hits, full_misses);
    $display("%0d meshes paid off, input held back for %0d cycles, %0d results checked",
             meshes_ok, in_stalled_cycles, results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("timeout after %0t ns", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
